[sv/multi_queue_hysteresis_priority_server_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the multi-queue server
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_HYSTERESIS_PRIORITY_SERVER_ASSERT_SVH
`define MULTI_QUEUE_HYSTERESIS_PRIORITY_SERVER_ASSERT_SVH

// same-cycle implication
`define MQHPS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mqhps check failed");

// next-cycle implication
`define MQHPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mqhps check failed");

`endif

[sv/mqhps_pkg.sv]
// ----------------------------------------------------------------------------
// mqhps_pkg
// Shared types, codes and constants of the multi-queue server.
// ----------------------------------------------------------------------------
package mqhps_pkg;

    localparam int NUM_ROADS       = 4;
    localparam int LANES_PER_ROAD  = 3;
    localparam int MAX_LANE        = NUM_ROADS * LANES_PER_ROAD;
    localparam int DEF_QUEUE_DEPTH = 16;

    localparam logic [1:0] RST_PRIO_LANE   = 2'd2;
    localparam logic [4:0] RST_ENTER_LEVEL = 5'd10;
    localparam logic [4:0] RST_EXIT_LEVEL  = 5'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_PRIO_LANE   = 2'd0;
    localparam logic [1:0] CFG_ENTER_LEVEL = 2'd1;
    localparam logic [1:0] CFG_EXIT_LEVEL  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_DROPPED  = 3'd1;
    localparam logic [2:0] ST_INVALID  = 3'd2;
    localparam logic [2:0] ST_SENT     = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    // input modes
    localparam logic MODE_ARRIVE = 1'b0;
    localparam logic MODE_SERVE  = 1'b1;

    typedef struct packed {
        logic       serve;
        logic       bad_lane;
        logic [1:0] road;
        logic [3:0] lane;
    } t_cmd;

    function automatic logic lane_ok(input logic [3:0] lane);
        return (lane >= 4'd1) && (lane <= 4'(MAX_LANE));
    endfunction

    function automatic logic [1:0] lane_road(input logic [3:0] lane);
        logic [1:0] road;
        case (lane) inside
            [4'd1:4'd3]:   road = 2'd0;
            [4'd4:4'd6]:   road = 2'd1;
            [4'd7:4'd9]:   road = 2'd2;
            [4'd10:4'd12]: road = 2'd3;
            default:       road = 2'd0;
        endcase
        return road;
    endfunction

endpackage

[sv/multi_queue_hysteresis_priority_server.sv]
// ----------------------------------------------------------------------------
// multi_queue_hysteresis_priority_server
// Four road queues of lane numbers with hysteresis-controlled priority
// extraction of one lane from road zero.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+--------------------------
//  in       | input     | i_in_valid / o_in_stall    | i_mode, i_arrival_lane
//  out      | output    | o_out_valid / i_out_stall  | o_status, o_sent_lane,
//           |           |                            | o_sent_road, o_priority_served
//  cfg      | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  Steps: a plain serve reads the head of the road served and then compacts
//  that road; a priority serve that finds its lane searches road zero up to
//  the match and then compacts road zero. A priority search with no match
//  scans all of road zero before the plain serve. All of this runs on the one
//  memory, which has one read port and one write port.
//  Two transactions may wait in the command queue while one executes.
//  Writing priority_lane recounts road zero, with cfg ready low meanwhile.
//  Reset is synchronous and active low; queue contents are not cleared.
//  A stalled output holds its transaction; new commands wait until it leaves.
// ----------------------------------------------------------------------------
`include "multi_queue_hysteresis_priority_server_assert.svh"

module multi_queue_hysteresis_priority_server #(
    parameter int QUEUE_DEPTH = mqhps_pkg::DEF_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_mode,
    input  logic [3:0] i_arrival_lane,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_status,
    output logic [3:0] o_sent_lane,
    output logic [1:0] o_sent_road,
    output logic       o_priority_served,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [4:0] i_cfg_data
);
    import mqhps_pkg::*;

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;
    logic out_nosend;
    logic out_sent;
    logic sent_match;
    logic cfg_lane_wr;

    // classify and queue incoming transactions
    mqhps_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_arrival_lane (i_arrival_lane),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_pop      (cmd_pop)
    );

    // execute commands against the road queues
    mqhps_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_valid       (cmd_valid),
        .i_cmd             (cmd),
        .o_cmd_pop         (cmd_pop),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_sent_lane       (o_sent_lane),
        .o_sent_road       (o_sent_road),
        .o_priority_served (o_priority_served)
    );

    assign out_nosend  = o_out_valid && (o_status != ST_SENT);
    assign out_sent    = o_out_valid && (o_status == ST_SENT);
    assign sent_match  = lane_ok(o_sent_lane) && (lane_road(o_sent_lane) == o_sent_road);
    assign cfg_lane_wr = i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_PRIO_LANE);

    // anything but a send carries no lane and no priority mark
    `MQHPS_ASSERT_NOW(a_nosend_clean, out_nosend, (o_sent_lane == 4'd0) && !o_priority_served)
    // a sent vehicle is a real lane of the reported road
    `MQHPS_ASSERT_NOW(a_sent_road, out_sent, sent_match)
    // priority extraction only ever serves road zero
    `MQHPS_ASSERT_NOW(a_prio_road0, o_out_valid && o_priority_served, (o_sent_road == 2'd0) && out_sent)
    // a priority lane write always starts a recount
    `MQHPS_ASSERT_NEXT(a_recount, cfg_lane_wr, !o_cfg_ready)

endmodule

[sv/mqhps_front.sv]
// ----------------------------------------------------------------------------
// mqhps_front
// Accepts items, classifies lane and road, and holds them in a two-entry
// command queue towards the execution side.
// ----------------------------------------------------------------------------
module mqhps_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_mode,
    input  logic [3:0]       i_arrival_lane,
    output logic             o_cmd_valid,
    output mqhps_pkg::t_cmd  o_cmd,
    input  logic             i_cmd_pop
);
    import mqhps_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       push;

    always_comb begin
        n_cmd.serve    = (i_mode == MODE_SERVE);
        n_cmd.bad_lane = !lane_ok(i_arrival_lane);
        n_cmd.road     = lane_road(i_arrival_lane);
        n_cmd.lane     = i_arrival_lane;
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_cmd_pop};
        end
    end

endmodule

[sv/mqhps_back.sv]
// ----------------------------------------------------------------------------
// mqhps_back
// Executes commands on the road queues: append, head pop, priority-lane
// search and compaction of road zero, and backlog recount on lane change.
// ----------------------------------------------------------------------------
module mqhps_back #(
    parameter int QUEUE_DEPTH = mqhps_pkg::DEF_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  mqhps_pkg::t_cmd  i_cmd,
    output logic             o_cmd_pop,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [4:0]       i_cfg_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [2:0]       o_status,
    output logic [3:0]       o_sent_lane,
    output logic [1:0]       o_sent_road,
    output logic             o_priority_served
);
    import mqhps_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = (CW > 5) ? CW : 5;
    localparam int MW = AW + 2;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_ORD, S_GRAB, S_SHIFT, S_RECOUNT
    } t_state;

    t_state        r_state;
    logic [3:0]    r_mem [NUM_ROADS << AW];
    logic [3:0]    r_rdata;
    logic [CW-1:0] r_fill [NUM_ROADS];
    logic [CW-1:0] r_backlog;
    logic          r_active;
    logic [1:0]    r_plane;
    logic [4:0]    r_enter;
    logic [4:0]    r_exit;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_ppos;
    logic          r_pend;
    logic [3:0]    r_val;
    logic [1:0]    r_road;
    logic          r_prio;
    logic          r_out_valid;
    logic [2:0]    r_status;
    logic [3:0]    r_lane_o;
    logic [1:0]    r_road_o;
    logic          r_prio_o;

    logic          out_free;
    logic          wr_en;
    logic [MW-1:0] wr_addr;
    logic [3:0]    wr_data;
    logic [MW-1:0] rd_addr;
    logic          n_active;
    logic          match;
    logic          any_busy;
    logic [1:0]    first_road;
    logic [CW-1:0] ppos_dec;
    logic          rd_more;
    logic          res_load;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_cmd_pop   = (r_state == S_IDLE) && !i_cfg_valid && i_cmd_valid && out_free;
    assign match       = r_pend && (r_rdata == {2'b00, r_plane});
    assign ppos_dec    = r_ppos - 1'b1;

    // a result is loaded on an arrival, on an empty serve and at the end of a send
    assign res_load = (o_cmd_pop && !i_cmd.serve)
                      || ((r_state == S_ORD) && !any_busy)
                      || ((r_state == S_SHIFT) && !rd_more);

    always_comb begin
        any_busy   = 1'b0;
        first_road = 2'd0;
        for (int r = NUM_ROADS - 1; r >= 0; r--) begin
            if (r_fill[r] != '0) begin
                any_busy   = 1'b1;
                first_road = 2'(r);
            end
        end
    end

    always_comb begin
        if (LW'(r_backlog) > LW'(r_enter)) begin
            n_active = 1'b1;
        end else if (LW'(r_backlog) < LW'(r_exit)) begin
            n_active = 1'b0;
        end else begin
            n_active = r_active;
        end
    end

    // memory port control
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {i_cmd.road, r_fill[i_cmd.road][AW-1:0]};
        wr_data = i_cmd.lane;
        rd_addr = {2'd0, r_idx[AW-1:0]};
        rd_more = 1'b0;
        case (r_state)
            S_IDLE: begin
                wr_en = o_cmd_pop && !i_cmd.serve && !i_cmd.bad_lane
                        && (r_fill[i_cmd.road] != CW'(QUEUE_DEPTH));
            end
            S_SCAN, S_RECOUNT: begin
                rd_more = (r_idx < r_fill[0]);
            end
            S_ORD: begin
                rd_addr = {first_road, {AW{1'b0}}};
            end
            S_SHIFT: begin
                rd_addr = {r_road, r_idx[AW-1:0]};
                rd_more = (r_idx < r_fill[r_road]);
                wr_en   = r_pend;
                wr_addr = {r_road, ppos_dec[AW-1:0]};
                wr_data = r_rdata;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '{default: '0};
            r_backlog   <= '0;
            r_active    <= 1'b0;
            r_plane     <= RST_PRIO_LANE;
            r_enter     <= RST_ENTER_LEVEL;
            r_exit      <= RST_EXIT_LEVEL;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= res_load || (r_out_valid && i_out_stall);
            case (r_state)
                S_IDLE: begin
                    r_pend <= 1'b0;
                    r_idx  <= '0;
                    if (i_cfg_valid) begin
                        case (i_cfg_index)
                            CFG_PRIO_LANE: begin
                                r_plane   <= i_cfg_data[1:0];
                                r_backlog <= '0;
                                r_state   <= S_RECOUNT;
                            end
                            CFG_ENTER_LEVEL: r_enter <= i_cfg_data;
                            CFG_EXIT_LEVEL:  r_exit  <= i_cfg_data;
                            default:         r_enter <= r_enter;
                        endcase
                    end else if (o_cmd_pop) begin
                        if (i_cmd.serve) begin
                            r_active <= n_active;
                            if (n_active && (LW'(r_backlog) >= LW'(r_exit))) begin
                                r_state <= S_SCAN;
                            end else begin
                                r_state <= S_ORD;
                            end
                        end else begin
                            r_lane_o    <= 4'd0;
                            r_prio_o    <= 1'b0;
                            if (i_cmd.bad_lane) begin
                                r_status <= ST_INVALID;
                                r_road_o <= 2'd0;
                            end else begin
                                r_road_o <= i_cmd.road;
                                if (wr_en) begin
                                    r_status <= ST_ACCEPTED;
                                    r_fill[i_cmd.road] <= r_fill[i_cmd.road] + 1'b1;
                                    if ((i_cmd.road == 2'd0)
                                        && (i_cmd.lane == {2'b00, r_plane})) begin
                                        r_backlog <= r_backlog + 1'b1;
                                    end
                                end else begin
                                    r_status <= ST_DROPPED;
                                end
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (match) begin
                        r_val   <= r_rdata;
                        r_road  <= 2'd0;
                        r_prio  <= 1'b1;
                        r_idx   <= r_ppos + 1'b1;
                        r_pend  <= 1'b0;
                        r_state <= S_SHIFT;
                    end else if (rd_more) begin
                        r_pend <= 1'b1;
                        r_ppos <= r_idx;
                        r_idx  <= r_idx + 1'b1;
                    end else begin
                        // nothing matched: fall back to plain service
                        r_pend  <= 1'b0;
                        r_state <= S_ORD;
                    end
                end
                S_ORD: begin
                    r_prio <= 1'b0;
                    r_road <= first_road;
                    if (any_busy) begin
                        r_state <= S_GRAB;
                    end else begin
                        r_status    <= ST_EMPTY;
                        r_lane_o    <= 4'd0;
                        r_road_o    <= 2'd0;
                        r_prio_o    <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                S_GRAB: begin
                    r_val   <= r_rdata;
                    r_idx   <= CW'(1);
                    r_pend  <= 1'b0;
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    if (rd_more) begin
                        r_pend <= 1'b1;
                        r_ppos <= r_idx;
                        r_idx  <= r_idx + 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        r_fill[r_road] <= r_fill[r_road] - 1'b1;
                        if ((r_road == 2'd0) && (r_val == {2'b00, r_plane})
                            && (r_backlog != '0)) begin
                            r_backlog <= r_backlog - 1'b1;
                        end
                        r_status    <= ST_SENT;
                        r_lane_o    <= r_val;
                        r_road_o    <= r_road;
                        r_prio_o    <= r_prio;
                        r_state     <= S_IDLE;
                    end
                end
                S_RECOUNT: begin
                    if (match) begin
                        r_backlog <= r_backlog + 1'b1;
                    end
                    if (rd_more) begin
                        r_pend <= 1'b1;
                        r_idx  <= r_idx + 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_sent_lane       = r_lane_o;
    assign o_sent_road       = r_road_o;
    assign o_priority_served = r_prio_o;

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - multi_queue_hysteresis_priority_server testbench
// Drives arrival and serve transactions with random idling on both sides,
// rewrites the configuration between phases and checks every result against
// a behavioural copy of the four road queues and the priority hysteresis.
// ----------------------------------------------------------------------------
module tb;
    import mqhps_pkg::*;

    localparam int DEPTH       = DEF_QUEUE_DEPTH;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [2:0] status;
        logic [3:0] lane;
        logic [1:0] road;
        logic       prio;
    } t_outcome;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic       i_mode = MODE_ARRIVE;
    logic [3:0] i_arrival_lane = 4'd0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [2:0] o_status;
    logic [3:0] o_sent_lane;
    logic [1:0] o_sent_road;
    logic       o_priority_served;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = CFG_PRIO_LANE;
    logic [4:0] i_cfg_data = 5'd0;

    // behavioural copy of the block state
    logic [3:0] road_q[NUM_ROADS][$];
    int         prio_backlog;
    logic       prio_on;
    logic [1:0] cfg_prio_lane;
    logic [4:0] cfg_enter;
    logic [4:0] cfg_exit;

    t_outcome   pending_outcomes[$];
    int         error_count = 0;
    int         cycle_count = 0;
    bit         idling_on = 1'b1;

    multi_queue_hysteresis_priority_server dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_arrival_lane   (i_arrival_lane),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_sent_lane      (o_sent_lane),
        .o_sent_road      (o_sent_road),
        .o_priority_served(o_priority_served),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Bound the run; a hang anywhere ends here as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("multi_queue_hysteresis_priority_server verification failed");
            $finish;
        end
    end

    // Output back-pressure: stall now and then, unless idling is switched off.
    always @(posedge i_clk) begin
        i_out_stall <= idling_on && ($urandom_range(99) < 6);
    end

    // Recount road zero entries that hold the watched lane.
    function automatic int count_backlog();
        int n = 0;
        foreach (road_q[0][k])
            if (road_q[0][k] == {2'b00, cfg_prio_lane}) n++;
        return n;
    endfunction

    // Drop one entry of a road, keeping the rest in order.
    function automatic logic [3:0] take_entry(int r, int pos);
        logic [3:0] v;
        v = road_q[r][pos];
        road_q[r].delete(pos);
        if (r == 0 && v == {2'b00, cfg_prio_lane} && prio_backlog > 0) prio_backlog--;
        return v;
    endfunction

    // Work out the result of one accepted transaction and advance the state.
    function automatic t_outcome serve_or_queue(logic mode, logic [3:0] lane);
        t_outcome o;
        int       r;
        bit       done = 0;
        o = '{status: ST_EMPTY, lane: 4'd0, road: 2'd0, prio: 1'b0};
        if (mode == MODE_ARRIVE) begin
            if (lane < 4'd1 || lane > 4'(MAX_LANE)) begin
                o.status = ST_INVALID;
            end else begin
                r = (lane - 1) / LANES_PER_ROAD;
                o.road = 2'(r);
                if (road_q[r].size() >= DEPTH) begin
                    o.status = ST_DROPPED;
                end else begin
                    road_q[r].push_back(lane);
                    if (r == 0 && lane == {2'b00, cfg_prio_lane}) prio_backlog++;
                    o.status = ST_ACCEPTED;
                end
            end
        end else begin
            // set test first, then the clear test
            if (prio_backlog > cfg_enter) prio_on = 1'b1;
            else if (prio_backlog < cfg_exit) prio_on = 1'b0;
            if (prio_on && prio_backlog >= cfg_exit) begin
                foreach (road_q[0][k]) begin
                    if (!done && road_q[0][k] == {2'b00, cfg_prio_lane}) begin
                        o.lane = take_entry(0, k);
                        o.prio = 1'b1;
                        done   = 1;
                    end
                end
            end
            // fall back to plain service in fixed road order
            for (r = 0; r < NUM_ROADS && !done; r++) begin
                if (road_q[r].size() > 0) begin
                    o.lane = take_entry(r, 0);
                    o.road = 2'(r);
                    done   = 1;
                end
            end
            o.status = done ? ST_SENT : ST_EMPTY;
        end
        return o;
    endfunction

    // Send one transaction, optionally after a random gap, and record its outcome.
    task automatic send_item(input logic mode, input logic [3:0] lane);
        if (idling_on && $urandom_range(99) < 6) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_arrival_lane <= lane;
        do @(posedge i_clk); while (o_in_stall);
        pending_outcomes.push_back(serve_or_queue(mode, lane));
    endtask

    // Hold until every outstanding result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_PRIO_LANE: begin
                cfg_prio_lane = value[1:0];
                prio_backlog  = count_backlog();
            end
            CFG_ENTER_LEVEL: cfg_enter = value;
            CFG_EXIT_LEVEL:  cfg_exit  = value;
            default: ;
        endcase
    endtask

    task automatic report(input string field, input int exp_v, input int act_v);
        $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
        error_count++;
    endtask

    // Compare each transaction leaving the block with the oldest expectation.
    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t ns: unexpected result, status %0d", $time, o_status);
                error_count++;
            end else begin
                e = pending_outcomes.pop_front();
                if (o_status != e.status) report("status", e.status, o_status);
                if (o_sent_lane != e.lane) report("sent_lane", e.lane, o_sent_lane);
                if (o_sent_road != e.road) report("sent_road", e.road, o_sent_road);
                if (o_priority_served != e.prio)
                    report("priority_served", e.prio, o_priority_served);
            end
        end
    end

    // Every lane code once, invalid ones included, then serve until empty.
    task automatic test_lanes_and_empty();
        send_item(MODE_SERVE, 4'd0);
        for (int l = 0; l < 16; l++) send_item(MODE_ARRIVE, 4'(l));
        repeat (MAX_LANE + 1) send_item(MODE_SERVE, 4'd15);
    endtask

    // Fill one road past its depth so the last arrivals are dropped.
    task automatic test_full_road();
        repeat (DEPTH + 2) send_item(MODE_ARRIVE, 4'd12);
        repeat (DEPTH) send_item(MODE_SERVE, 4'd0);
    endtask

    // Build a backlog on the watched lane and watch the flag switch on and off.
    task automatic test_priority_hysteresis();
        write_reg(CFG_PRIO_LANE, 5'd3);
        write_reg(CFG_ENTER_LEVEL, 5'd2);
        write_reg(CFG_EXIT_LEVEL, 5'd2);
        send_item(MODE_ARRIVE, 4'd1);
        send_item(MODE_ARRIVE, 4'd2);
        repeat (4) send_item(MODE_ARRIVE, 4'd3);
        send_item(MODE_ARRIVE, 4'd5);
        repeat (8) send_item(MODE_SERVE, 4'd0);
        // enter below exit, then a lane that never matches
        write_reg(CFG_ENTER_LEVEL, 5'd0);
        write_reg(CFG_EXIT_LEVEL, 5'd31);
        repeat (3) send_item(MODE_ARRIVE, 4'd3);
        send_item(MODE_SERVE, 4'd0);
        write_reg(CFG_PRIO_LANE, 5'd0);
        send_item(MODE_SERVE, 4'd0);
        send_item(MODE_SERVE, 4'd0);
    endtask

    // Random phases, each under its own register setting.
    task automatic test_random_traffic();
        int          serve_pct;
        int          road0_pct;
        logic [4:0]  lv_enter;
        logic [4:0]  lv_exit;
        logic [3:0]  lane;
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin lv_enter = 5'd0;  lv_exit = 5'd0;  end
                1: begin lv_enter = 5'd16; lv_exit = 5'd16; end
                2: begin lv_enter = 5'd31; lv_exit = 5'd31; end
                3: begin lv_enter = 5'd10; lv_exit = 5'd5;  end
                default: begin
                    lv_enter = 5'($urandom_range(0, 16));
                    lv_exit  = 5'($urandom_range(0, 16));
                end
            endcase
            write_reg(CFG_PRIO_LANE, 5'($urandom_range(0, 31)));
            write_reg(CFG_ENTER_LEVEL, lv_enter);
            write_reg(CFG_EXIT_LEVEL, lv_exit);
            // one phase runs with no idling on either side
            idling_on = (ph != 5);
            for (int n = 0; n < 150; n++) begin
                // drift between filling and draining so queues hit both ends
                serve_pct = ((n / 30) % 2) ? 70 : 30;
                road0_pct = 60;
                if ($urandom_range(99) < serve_pct) begin
                    send_item(MODE_SERVE, 4'($urandom));
                end else begin
                    if ($urandom_range(99) < 3)
                        lane = ($urandom_range(1)) ? 4'd0 : 4'($urandom_range(13, 15));
                    else if ($urandom_range(99) < road0_pct)
                        lane = 4'($urandom_range(1, 3));
                    else
                        lane = 4'($urandom_range(4, 12));
                    send_item(MODE_ARRIVE, lane);
                end
            end
        end
        idling_on = 1'b1;
    endtask

    initial begin
        for (int r = 0; r < NUM_ROADS; r++) road_q[r].delete();
        prio_backlog  = 0;
        prio_on       = 1'b0;
        cfg_prio_lane = RST_PRIO_LANE;
        cfg_enter     = RST_ENTER_LEVEL;
        cfg_exit      = RST_EXIT_LEVEL;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_lanes_and_empty();
        test_full_road();
        test_priority_hysteresis();
        test_random_traffic();

        drain_results();
        repeat (60) @(posedge i_clk);
        if (error_count == 0 && pending_outcomes.size() == 0) begin
            $display("multi_queue_hysteresis_priority_server verification clean");
        end else begin
            $display("multi_queue_hysteresis_priority_server verification failed");
        end
        $finish;
    end

endmodule
